// ===== sv/wrgs_pkg.sv =====
// shared types and constants for the windowed rms gate segmenter
`default_nettype none

package wrgs_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CHANNELS_DEF    = 2;

	localparam int WLEN_W     = 16;
	localparam int LEVEL_W    = 31;
	localparam int HOLD_W     = 16;
	localparam int CNT_W      = 32;
	localparam int E_W        = 63;
	localparam int THR_W      = 48;
	localparam int PROD_W     = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_WINDOWS    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEAD_FRAMES = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LEVEL   = CFG_IDX_W'(4);

	localparam logic [WLEN_W-1:0]  WINDOW_LEN_RST      = WLEN_W'(480);
	localparam logic [LEVEL_W-1:0] THRESHOLD_LEVEL_RST = LEVEL_W'(107374);
	localparam logic [HOLD_W-1:0]  HOLD_WINDOWS_RST    = '0;
	localparam logic [CNT_W-1:0]   MIN_DEAD_FRAMES_RST = '0;
	localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RST   = LEVEL_W'(1);

	localparam logic [CNT_W-1:0] MIN_BUFFER_FRAMES = CNT_W'(128);
	localparam logic [E_W-1:0]   E_MAX             = '1;

	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic             region_valid;
		logic             is_live;
		logic [CNT_W-1:0] start_window;
		logic [CNT_W-1:0] end_window;
		logic [E_W-1:0]   energy_sum;
		logic [CNT_W-1:0] frame_count;
		logic             is_silence;
		logic             scan_done;
	} result_t;

	typedef struct packed {
		logic    vld;
		result_t res;
	} slot_t;

	typedef struct packed {
		logic                  space2;
		logic [OUTQ_CNT_W-1:0] count;
	} outq_stat_t;

endpackage

`default_nettype wire

// ===== sv/wrgs_front.sv =====
// input register stage: sample magnitudes squared and summed over channels
`default_nettype none

module wrgs_front import wrgs_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CHANNELS    = CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic                          in_valid,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          last_frame,
	output logic                          vld_s1,
	output logic [2*SAMPLE_BITS-1:0]      sq_s1,
	output logic                          last_s1
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam logic USE_RIGHT = (CHANNELS > 1);

	logic [SAMPLE_BITS-1:0] mag_l;
	logic [SAMPLE_BITS-1:0] mag_r;
	logic [SQ_W-1:0]        sq_l;
	logic [SQ_W-1:0]        sq_r;
	logic [SQ_W-1:0]        sq_sum;

	// most negative code maps to its true magnitude as unsigned
	assign mag_l = left_sample[SAMPLE_BITS-1] ?
		SAMPLE_BITS'(~left_sample) + SAMPLE_BITS'(1) : SAMPLE_BITS'(left_sample);
	assign mag_r = right_sample[SAMPLE_BITS-1] ?
		SAMPLE_BITS'(~right_sample) + SAMPLE_BITS'(1) : SAMPLE_BITS'(right_sample);

	assign sq_l   = SQ_W'(mag_l) * SQ_W'(mag_l);
	assign sq_r   = SQ_W'(mag_r) * SQ_W'(mag_r);
	assign sq_sum = sq_l + (USE_RIGHT ? sq_r : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sq_s1   <= sq_sum;
			last_s1 <= last_frame;
		end
	end

endmodule

`default_nettype wire

// ===== sv/wrgs_gate.sv =====
// window accumulation, gate decision with hold, and region tracking
`default_nettype none

module wrgs_gate import wrgs_pkg::*; #(
	parameter int SQ_W = 2 * SAMPLE_BITS_DEF,
	parameter int WE_W = 2 * SAMPLE_BITS_DEF + WLEN_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              vld_s1,
	input  logic [SQ_W-1:0]   sq_s1,
	input  logic              last_s1,
	input  logic [WLEN_W-1:0] win_len,
	input  logic [THR_W-1:0]  thr,
	input  logic [HOLD_W-1:0] hold_windows,
	input  logic [CNT_W-1:0]  min_dead,
	output slot_t             slot0_s2,
	output slot_t             slot1_s2
);

	logic [WE_W-1:0]   we_q, we_sum, we_n;
	logic [WLEN_W-1:0] fiw_q, fiw_inc, fiw_n;
	logic [CNT_W-1:0]  wi_q, wi_n;
	logic [CNT_W-1:0]  tf_q, tf_n;
	logic [CNT_W-1:0]  ss_q, ss_n;
	logic [CNT_W-1:0]  sf_q, sf_n;
	logic [E_W-1:0]    se_q, se_n;
	logic              sl_q, sl_n;
	logic              so_q, so_n;
	logic [HOLD_W-1:0] hold_q, hold_n, hold_w;
	logic              win_end, thr_hit, live, extend;
	logic [E_W:0]      se_add;
	logic [CNT_W:0]    sf_add;
	logic              emit0, keep0, keep1;
	result_t           r0, r1;

	always_comb begin
		we_sum  = we_q + WE_W'(sq_s1);
		tf_n    = (tf_q == '1) ? tf_q : tf_q + CNT_W'(1);
		fiw_inc = fiw_q + WLEN_W'(1);
		win_end = fiw_inc >= win_len;
		thr_hit = PROD_W'(we_sum) >= PROD_W'(thr);
		se_add  = {1'b0, se_q} + (E_W+1)'(we_sum);
		sf_add  = {1'b0, sf_q} + (CNT_W+1)'(win_len);

		// hold keeps the gate open after a live window
		live   = 1'b0;
		hold_w = hold_q;
		if (thr_hit) begin
			live   = 1'b1;
			hold_w = hold_windows;
		end else if (hold_q != '0) begin
			live   = 1'b1;
			hold_w = hold_q - HOLD_W'(1);
		end
		extend = so_q && (live == sl_q);

		we_n   = we_sum;
		fiw_n  = fiw_inc;
		wi_n   = wi_q;
		hold_n = hold_q;
		ss_n   = ss_q;
		se_n   = se_q;
		sf_n   = sf_q;
		sl_n   = sl_q;
		so_n   = so_q;
		emit0  = 1'b0;
		if (win_end) begin
			we_n   = '0;
			fiw_n  = '0;
			wi_n   = wi_q + CNT_W'(1);
			hold_n = hold_w;
			if (extend) begin
				se_n = se_add[E_W] ? E_MAX : se_add[E_W-1:0];
				sf_n = sf_add[CNT_W] ? '1 : sf_add[CNT_W-1:0];
			end else begin
				emit0 = so_q;
				so_n  = 1'b1;
				sl_n  = live;
				ss_n  = wi_q;
				se_n  = E_W'(we_sum);
				sf_n  = CNT_W'(win_len);
			end
		end

		// region closed by a change of gate state
		keep0           = emit0 && (sl_q || (sf_q >= min_dead));
		r0              = '0;
		r0.region_valid = 1'b1;
		r0.is_live      = sl_q;
		r0.start_window = ss_q;
		r0.end_window   = wi_q;
		r0.energy_sum   = se_q;
		r0.frame_count  = sf_q;

		// closing result at the end of the buffer
		keep1        = so_n && (tf_n >= MIN_BUFFER_FRAMES) && (sl_n || (sf_n >= min_dead));
		r1           = '0;
		r1.scan_done = 1'b1;
		if (keep1) begin
			r1.region_valid = 1'b1;
			r1.is_live      = sl_n;
			r1.start_window = ss_n;
			r1.end_window   = wi_n;
			r1.energy_sum   = se_n;
			r1.frame_count  = sf_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_q     <= '0;
			fiw_q    <= '0;
			wi_q     <= '0;
			tf_q     <= '0;
			ss_q     <= '0;
			se_q     <= '0;
			sf_q     <= '0;
			sl_q     <= 1'b0;
			so_q     <= 1'b0;
			hold_q   <= '0;
			slot0_s2 <= '0;
			slot1_s2 <= '0;
		end else if (advance) begin
			slot0_s2.vld <= vld_s1 && keep0;
			slot0_s2.res <= r0;
			slot1_s2.vld <= vld_s1 && last_s1;
			slot1_s2.res <= r1;
			if (vld_s1) begin
				if (last_s1) begin
					we_q   <= '0;
					fiw_q  <= '0;
					wi_q   <= '0;
					tf_q   <= '0;
					ss_q   <= '0;
					se_q   <= '0;
					sf_q   <= '0;
					sl_q   <= 1'b0;
					so_q   <= 1'b0;
					hold_q <= '0;
				end else begin
					we_q   <= we_n;
					fiw_q  <= fiw_n;
					wi_q   <= wi_n;
					tf_q   <= tf_n;
					ss_q   <= ss_n;
					se_q   <= se_n;
					sf_q   <= sf_n;
					sl_q   <= sl_n;
					so_q   <= so_n;
					hold_q <= hold_n;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/wrgs_silence.sv =====
// silence test for dead regions: level times frames product, then compare
`default_nettype none

module wrgs_silence import wrgs_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic [LEVEL_W-1:0] silence_level,
	input  slot_t              slot0_s2,
	input  slot_t              slot1_s2,
	output slot_t              slot0_o,
	output slot_t              slot1_o
);

	slot_t             slot0_s3, slot1_s3;
	logic [PROD_W-1:0] prod_s3;
	logic              dead0;
	logic [CNT_W-1:0]  dead_frames;
	logic [E_W-1:0]    mult;

	// the two results of one frame differ in gate state, so one product serves
	assign dead0       = slot0_s2.vld && !slot0_s2.res.is_live;
	assign dead_frames = dead0 ? slot0_s2.res.frame_count : slot1_s2.res.frame_count;
	assign mult        = E_W'(silence_level) * E_W'(dead_frames);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_s3 <= '0;
			slot1_s3 <= '0;
		end else if (advance) begin
			slot0_s3 <= slot0_s2;
			slot1_s3 <= slot1_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s3 <= PROD_W'(mult) << (CHANNELS - 1);
		end
	end

	always_comb begin
		slot0_o                = slot0_s3;
		slot1_o                = slot1_s3;
		slot0_o.res.is_silence = slot0_s3.res.region_valid && !slot0_s3.res.is_live &&
			(PROD_W'(slot0_s3.res.energy_sum) < prod_s3);
		slot1_o.res.is_silence = slot1_s3.res.region_valid && !slot1_s3.res.is_live &&
			(PROD_W'(slot1_s3.res.energy_sum) < prod_s3);
	end

endmodule

`default_nettype wire

// ===== sv/wrgs_outq.sv =====
// result queue, up to two writes and one read per cycle
`default_nettype none

module wrgs_outq import wrgs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  slot_t      slot0,
	input  slot_t      slot1,
	input  logic       out_stall,
	output logic       out_valid,
	output result_t    head,
	output outq_stat_t stat
);

	result_t               mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] wp_q, rp_q, wp_1;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  push0, push1, pop;
	logic [1:0]            npush;

	assign push0 = advance && slot0.vld;
	assign push1 = advance && slot1.vld;
	assign npush = {push0 && push1, push0 ^ push1};
	assign wp_1  = wp_q + OUTQ_PTR_W'(1);

	assign out_valid   = cnt_q != '0;
	assign pop         = out_valid && !out_stall;
	assign head        = mem[rp_q];
	assign stat.count  = cnt_q;
	assign stat.space2 = cnt_q <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push0) begin
			mem[wp_q] <= slot0.res;
		end
		if (push1) begin
			mem[push0 ? wp_1 : wp_q] <= slot1.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_W'(npush);
			rp_q  <= rp_q + OUTQ_PTR_W'(pop);
			cnt_q <= cnt_q + OUTQ_CNT_W'(npush) - OUTQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== sv/windowed_rms_gate_segmenter.sv =====
// Windowed rms gate segmenter, top level.
// Frames come in on in_valid/in_stall: one stereo frame per transfer, last_frame on the
// final frame of a buffer. Regions go out on out_valid/out_stall, one result per transfer.
// Configuration registers are written on cfg_valid/cfg_ready (always ready) by index. The
// user must write them only while no frame is in flight; the block does not enforce it.
// Throughput: one frame per cycle while in_stall is low. A frame gives zero, one or two
// results; two only on the last frame when the gate also changes state there.
// A result passes from its frame through the square stage, gate stage, silence product
// stage and result queue to the output.
// The pipeline moves as one; it holds (in_stall high) whenever the four-entry result
// queue has fewer than two free entries, so a stalled receiver backs up to the input
// and nothing is dropped.
// Reset clears all gate state and the queue and loads the default register values.
// After the last frame of a buffer the gate state returns to reset; registers keep.
`default_nettype none

module windowed_rms_gate_segmenter import wrgs_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CHANNELS    = CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          last_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          region_valid,
	output logic                          is_live,
	output logic [CNT_W-1:0]              start_window,
	output logic [CNT_W-1:0]              end_window,
	output logic [E_W-1:0]                energy_sum,
	output logic [CNT_W-1:0]              frame_count,
	output logic                          is_silence,
	output logic                          scan_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int WE_W = 2 * SAMPLE_BITS + WLEN_W;

	logic [WLEN_W-1:0]  window_len_q;
	logic [LEVEL_W-1:0] threshold_level_q;
	logic [HOLD_W-1:0]  hold_windows_q;
	logic [CNT_W-1:0]   min_dead_frames_q;
	logic [LEVEL_W-1:0] silence_level_q;
	logic [WLEN_W-1:0]  win_len;
	logic [THR_W-1:0]   thr_prod, thr_q;
	logic               advance;
	logic               vld_s1, last_s1;
	logic [SQ_W-1:0]    sq_s1;
	slot_t              slot0_s2, slot1_s2, slot0_c, slot1_c;
	result_t            head;
	outq_stat_t         stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q      <= WINDOW_LEN_RST;
			threshold_level_q <= THRESHOLD_LEVEL_RST;
			hold_windows_q    <= HOLD_WINDOWS_RST;
			min_dead_frames_q <= MIN_DEAD_FRAMES_RST;
			silence_level_q   <= SILENCE_LEVEL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_LEN:      window_len_q      <= cfg_data[WLEN_W-1:0];
				CFG_THRESHOLD_LEVEL: threshold_level_q <= cfg_data[LEVEL_W-1:0];
				CFG_HOLD_WINDOWS:    hold_windows_q    <= cfg_data[HOLD_W-1:0];
				CFG_MIN_DEAD_FRAMES: min_dead_frames_q <= cfg_data[CNT_W-1:0];
				CFG_SILENCE_LEVEL:   silence_level_q   <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// a zero window length behaves as one frame
	assign win_len  = (window_len_q == '0) ? WLEN_W'(1) : window_len_q;
	assign thr_prod = THR_W'(threshold_level_q) * THR_W'(win_len);

	// live threshold in window energy units, settled before a frame reaches the gate
	always_ff @(posedge clk) begin
		thr_q <= thr_prod << (CHANNELS - 1);
	end

	assign advance  = stat.space2;
	assign in_stall = !advance;

	wrgs_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.CHANNELS   (CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_valid    (in_valid),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.last_frame  (last_frame),
		.vld_s1      (vld_s1),
		.sq_s1       (sq_s1),
		.last_s1     (last_s1)
	);

	wrgs_gate #(
		.SQ_W(SQ_W),
		.WE_W(WE_W)
	) u_gate (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.vld_s1      (vld_s1),
		.sq_s1       (sq_s1),
		.last_s1     (last_s1),
		.win_len     (win_len),
		.thr         (thr_q),
		.hold_windows(hold_windows_q),
		.min_dead    (min_dead_frames_q),
		.slot0_s2    (slot0_s2),
		.slot1_s2    (slot1_s2)
	);

	wrgs_silence #(
		.CHANNELS(CHANNELS)
	) u_silence (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.silence_level(silence_level_q),
		.slot0_s2     (slot0_s2),
		.slot1_s2     (slot1_s2),
		.slot0_o      (slot0_c),
		.slot1_o      (slot1_c)
	);

	wrgs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.slot0    (slot0_c),
		.slot1    (slot1_c),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.head     (head),
		.stat     (stat)
	);

	assign region_valid = head.region_valid;
	assign is_live      = head.is_live;
	assign start_window = head.start_window;
	assign end_window   = head.end_window;
	assign energy_sum   = head.energy_sum;
	assign frame_count  = head.frame_count;
	assign is_silence   = head.is_silence;
	assign scan_done    = head.scan_done;

	a_empty_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !region_valid |-> scan_done && !is_silence &&
			frame_count == '0 && energy_sum == '0)
		else $error("empty result is not a bare closing result");

	a_silence_dead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_silence |-> region_valid && !is_live)
		else $error("silence flag on a live or empty result");

	a_region_frames: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && region_valid |-> frame_count != '0)
		else $error("reported region has no frames");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.space2 |=> stat.count <= OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overrun");

endmodule

`default_nettype wire
